[rtl/core/character_lcd_cell_renderer_defines.svh]
// Assertion macros for the character LCD cell renderer.
// Included by the top level; depends on nothing else.
`ifndef CHARACTER_LCD_CELL_RENDERER_DEFINES_SVH
`define CHARACTER_LCD_CELL_RENDERER_DEFINES_SVH

// Whenever ante holds outside reset, cons must hold in the same cycle.
`define CCLR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The expression must never hold outside reset.
`define CCLR_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

[rtl/core/cclr_pkg.sv]
// Shared types and constants of the character LCD cell renderer.
// Used by every module of the block; depends on nothing.
package cclr_pkg;

   localparam int TEXT_ROWS_DEF  = 4;
   localparam int TEXT_COLS_DEF  = 16;
   localparam int FONT_CHARS_DEF = 256;

   localparam int GLYPH_LINES = 8;
   localparam int LINE_PIX    = 5;
   localparam int GLYPH_BITS  = GLYPH_LINES * LINE_PIX;
   localparam int LINE_IDX_W  = $clog2(GLYPH_LINES);

   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] SPACE_CODE = 8'h20;

   // Bottom two glyph lines, used for the underline cursor.
   localparam logic [GLYPH_BITS-1:0] UNDERLINE_MASK =
      {{(GLYPH_BITS - 2 * LINE_PIX){1'b0}}, {(2 * LINE_PIX){1'b1}}};

   localparam logic [2:0] CMD_WRITE_CHAR  = 3'd0;
   localparam logic [2:0] CMD_SET_CURSOR  = 3'd1;
   localparam logic [2:0] CMD_CLEAR       = 3'd2;
   localparam logic [2:0] CMD_BLINK_PHASE = 3'd3;
   localparam logic [2:0] CMD_LOAD_FONT   = 3'd4;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_COLS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_ROWS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UNDERLINE_EN  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_ENABLED = 3'd3;

   localparam logic [4:0] NUM_COLS_RST = 5'd16;
   localparam logic [2:0] NUM_ROWS_RST = 3'd2;

   typedef enum logic [2:0] {
      OP_WRITE,
      OP_SETCUR,
      OP_CLEAR,
      OP_BLINK,
      OP_FONT
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [7:0]            char_code;
      logic [7:0]            cursor_row;
      logic [7:0]            cursor_col;
      logic                  blink_phase;
      logic [LINE_IDX_W-1:0] font_line;
      logic [LINE_PIX-1:0]   font_bits;
   } cmd_type;

   typedef struct packed {
      logic [4:0] num_cols;
      logic [2:0] num_rows;
      logic       underline_en;
      logic       blink_enabled;
   } cfg_type;

   typedef struct packed {
      logic init_busy;
      logic idle;
   } back_status_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_TEXT,
      ST_FONT,
      ST_EMIT,
      ST_NEXT,
      ST_STORE,
      ST_CLR_STORE
   } state_type;

endpackage

[rtl/core/cclr_queue.sv]
// Short command queue between the front and back parts of the renderer.
// Depends on cclr_pkg for the command type and depth.
module cclr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cclr_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output cclr_pkg::cmd_type head
);

   localparam int PTR_W = (cclr_pkg::QUEUE_DEPTH > 1) ? $clog2(cclr_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(cclr_pkg::QUEUE_DEPTH + 1);

   cclr_pkg::cmd_type entries_ff [cclr_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(cclr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(cclr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full      = (count_ff == CNT_W'(cclr_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entries_ff[rd_ptr_ff];

endmodule

[rtl/core/cclr_front.sv]
// Front part of the renderer: takes requests and classifies them into queue entries.
// Depends on cclr_pkg for command codes and the queue entry type.
module cclr_front (
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_cmd,
   input  logic [7:0]                req_char_code,
   input  logic [7:0]                req_cursor_row,
   input  logic [7:0]                req_cursor_col,
   input  logic                      req_blink_phase,
   input  logic [2:0]                req_font_line,
   input  logic [4:0]                req_font_bits,
   input  logic                      q_full,
   input  cclr_pkg::back_status_type back_status,
   output logic                      q_push,
   output cclr_pkg::cmd_type         q_push_data
);

   logic known;

   always_comb begin
      known          = 1'b1;
      q_push_data.op = cclr_pkg::OP_WRITE;
      unique case (req_cmd)
         cclr_pkg::CMD_WRITE_CHAR:  q_push_data.op = cclr_pkg::OP_WRITE;
         cclr_pkg::CMD_SET_CURSOR:  q_push_data.op = cclr_pkg::OP_SETCUR;
         cclr_pkg::CMD_CLEAR:       q_push_data.op = cclr_pkg::OP_CLEAR;
         cclr_pkg::CMD_BLINK_PHASE: q_push_data.op = cclr_pkg::OP_BLINK;
         cclr_pkg::CMD_LOAD_FONT:   q_push_data.op = cclr_pkg::OP_FONT;
         default:                   known = 1'b0;
      endcase
      q_push_data.char_code   = req_char_code;
      q_push_data.cursor_row  = req_cursor_row;
      q_push_data.cursor_col  = req_cursor_col;
      q_push_data.blink_phase = req_blink_phase;
      q_push_data.font_line   = req_font_line;
      q_push_data.font_bits   = req_font_bits;
   end

   // Unused command codes are taken and dropped here.
   assign req_stall = q_full || back_status.init_busy;
   assign q_push    = req_valid && !req_stall && known;

endmodule

[rtl/core/cclr_back.sv]
// Back part of the renderer: text and font memories, cursor state and the render sequencer.
// Depends on cclr_pkg for types, states and constants.
module cclr_back #(
   parameter int TEXT_ROWS  = cclr_pkg::TEXT_ROWS_DEF,
   parameter int TEXT_COLS  = cclr_pkg::TEXT_COLS_DEF,
   parameter int FONT_CHARS = cclr_pkg::FONT_CHARS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cclr_pkg::cfg_type                   cfg,
   input  logic                                q_not_empty,
   input  cclr_pkg::cmd_type                   q_head,
   output logic                                q_pop,
   output cclr_pkg::back_status_type           status,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_cell_row,
   output logic [3:0]                          rsp_cell_col,
   output logic [cclr_pkg::GLYPH_BITS-1:0]     rsp_cell_pixels,
   output logic                                rsp_last
);

   localparam int TEXT_DEPTH = TEXT_ROWS * TEXT_COLS;
   localparam int TEXT_IDX_W = $clog2(TEXT_DEPTH);
   localparam int ROW_W      = (TEXT_ROWS > 1) ? $clog2(TEXT_ROWS) : 1;
   localparam int COL_W      = $clog2(TEXT_COLS);
   localparam int FC_W       = $clog2(FONT_CHARS);

   typedef struct packed {
      logic                                 pop;
      logic                                 text_we;
      logic [7:0]                           text_wdata;
      logic                                 font_we;
      logic [cclr_pkg::GLYPH_LINES-1:0]     font_lane_en;
      logic [FC_W-1:0]                      font_waddr;
      logic [cclr_pkg::LINE_PIX-1:0]        font_wdata;
      logic                                 out_load;
   } ctl_type;

   cclr_pkg::state_type state_ff, state_in;
   ctl_type             ctl;
   cclr_pkg::cmd_type   cmd_ff;

   logic [7:0]      cell_row_ff, cell_col_ff;
   logic [7:0]      cur_row_ff, cur_col_ff;
   logic            with_cur_ff, last_ff, second_ff, blink_inv_ff;
   logic [FC_W-1:0] init_cnt_ff;

   logic [7:0]                       text_mem [TEXT_DEPTH];
   logic [TEXT_DEPTH-1:0]            text_vld_ff;
   logic [cclr_pkg::GLYPH_BITS-1:0]  font_mem [FONT_CHARS];
   logic [7:0]                       text_rd_ff;
   logic                             text_vld_rd_ff;
   logic [cclr_pkg::GLYPH_BITS-1:0]  font_rd_ff;
   logic                             code_big_ff;

   logic                             rsp_valid_ff;
   logic [1:0]                       rsp_row_ff;
   logic [3:0]                       rsp_col_ff;
   logic [cclr_pkg::GLYPH_BITS-1:0]  rsp_pix_ff;
   logic                             rsp_last_ff;

   logic [7:0]                       act_rows, act_cols;
   logic                             in_area, area_empty, row_end, col_end;
   logic [TEXT_IDX_W-1:0]            text_idx;
   logic [7:0]                       text_code;
   logic                             code_big, here, out_free;
   logic [cclr_pkg::GLYPH_BITS-1:0]  pix;

   // Active area and the current cell.
   assign act_rows = ({5'd0, cfg.num_rows} < 8'(TEXT_ROWS)) ? {5'd0, cfg.num_rows}
                                                            : 8'(TEXT_ROWS);
   assign act_cols = ({3'd0, cfg.num_cols} < 8'(TEXT_COLS)) ? {3'd0, cfg.num_cols}
                                                            : 8'(TEXT_COLS);
   assign in_area    = (cell_row_ff < act_rows) && (cell_col_ff < act_cols);
   assign area_empty = (act_rows == 8'd0) || (act_cols == 8'd0);
   assign row_end    = ((cell_row_ff + 8'd1) == act_rows);
   assign col_end    = ((cell_col_ff + 8'd1) == act_cols);
   assign text_idx   = TEXT_IDX_W'(TEXT_IDX_W'(cell_row_ff[ROW_W-1:0]) * TEXT_IDX_W'(TEXT_COLS))
                     + TEXT_IDX_W'(cell_col_ff[COL_W-1:0]);

   // A text entry that was never written reads as a space.
   assign text_code = text_vld_rd_ff ? text_rd_ff : cclr_pkg::SPACE_CODE;
   assign code_big  = ({1'b0, text_code} >= 9'(FONT_CHARS));
   assign here      = with_cur_ff && (cell_row_ff == cur_row_ff) && (cell_col_ff == cur_col_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      pix = code_big_ff ? '0 : font_rd_ff;
      if (here && cfg.blink_enabled && blink_inv_ff) begin
         pix = '1;
      end else if (here && cfg.underline_en) begin
         pix = pix | cclr_pkg::UNDERLINE_MASK;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         cclr_pkg::ST_INIT: begin
            if (init_cnt_ff == FC_W'(FONT_CHARS - 1)) state_in = cclr_pkg::ST_IDLE;
         end
         cclr_pkg::ST_IDLE: begin
            if (q_not_empty) begin
               unique case (q_head.op)
                  cclr_pkg::OP_WRITE,
                  cclr_pkg::OP_SETCUR,
                  cclr_pkg::OP_BLINK: state_in = cclr_pkg::ST_TEXT;
                  cclr_pkg::OP_CLEAR: begin
                     state_in = area_empty ? cclr_pkg::ST_IDLE : cclr_pkg::ST_CLR_STORE;
                  end
                  default:            state_in = cclr_pkg::ST_IDLE;
               endcase
            end
         end
         cclr_pkg::ST_TEXT:  state_in = in_area ? cclr_pkg::ST_FONT : cclr_pkg::ST_NEXT;
         cclr_pkg::ST_FONT:  state_in = cclr_pkg::ST_EMIT;
         cclr_pkg::ST_EMIT: begin
            if (out_free) state_in = cclr_pkg::ST_NEXT;
         end
         cclr_pkg::ST_NEXT: begin
            priority if (cmd_ff.op == cclr_pkg::OP_WRITE && !second_ff) begin
               state_in = cclr_pkg::ST_STORE;
            end else if (cmd_ff.op == cclr_pkg::OP_CLEAR && !last_ff) begin
               state_in = cclr_pkg::ST_CLR_STORE;
            end else begin
               state_in = cclr_pkg::ST_IDLE;
            end
         end
         cclr_pkg::ST_STORE:     state_in = cclr_pkg::ST_TEXT;
         cclr_pkg::ST_CLR_STORE: state_in = cclr_pkg::ST_TEXT;
         default:                state_in = cclr_pkg::ST_IDLE;
      endcase
   end

   // Control strobes per state.
   always_comb begin
      ctl = '0;
      unique case (state_ff)
         cclr_pkg::ST_INIT: begin
            ctl.font_we      = 1'b1;
            ctl.font_lane_en = '1;
            ctl.font_waddr   = init_cnt_ff;
         end
         cclr_pkg::ST_IDLE: begin
            ctl.pop        = q_not_empty;
            ctl.font_waddr = q_head.char_code[FC_W-1:0];
            ctl.font_wdata = q_head.font_bits;
            ctl.font_we    = q_not_empty && (q_head.op == cclr_pkg::OP_FONT)
                             && ({1'b0, q_head.char_code} < 9'(FONT_CHARS));
            for (int l = 0; l < cclr_pkg::GLYPH_LINES; l++) begin
               ctl.font_lane_en[l] =
                  (q_head.font_line == cclr_pkg::LINE_IDX_W'(cclr_pkg::GLYPH_LINES - 1 - l));
            end
         end
         cclr_pkg::ST_STORE: begin
            ctl.text_we    = in_area;
            ctl.text_wdata = cmd_ff.char_code;
         end
         cclr_pkg::ST_CLR_STORE: begin
            ctl.text_we    = 1'b1;
            ctl.text_wdata = cclr_pkg::SPACE_CODE;
         end
         cclr_pkg::ST_EMIT: ctl.out_load = out_free;
         default: ;
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cclr_pkg::ST_INIT;
         init_cnt_ff  <= '0;
         cur_row_ff   <= '0;
         cur_col_ff   <= '0;
         blink_inv_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == cclr_pkg::ST_INIT) begin
            init_cnt_ff <= init_cnt_ff + FC_W'(1);
         end
         if (ctl.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctl.pop) begin
            unique case (q_head.op)
               cclr_pkg::OP_SETCUR: begin
                  cur_row_ff <= q_head.cursor_row;
                  cur_col_ff <= q_head.cursor_col;
               end
               cclr_pkg::OP_CLEAR: begin
                  cur_row_ff <= '0;
                  cur_col_ff <= '0;
               end
               cclr_pkg::OP_BLINK: blink_inv_ff <= q_head.blink_phase;
               default: ;
            endcase
         end
         if (state_ff == cclr_pkg::ST_STORE && cur_col_ff != 8'hFF) begin
            cur_col_ff <= cur_col_ff + 8'd1;
         end
      end
   end

   // Command and cell registers.
   always_ff @(posedge clock) begin
      if (ctl.pop) begin
         cmd_ff      <= q_head;
         second_ff   <= 1'b0;
         with_cur_ff <= (q_head.op == cclr_pkg::OP_BLINK);
         last_ff     <= (q_head.op != cclr_pkg::OP_WRITE);
         if (q_head.op == cclr_pkg::OP_CLEAR) begin
            cell_row_ff <= '0;
            cell_col_ff <= '0;
         end else begin
            cell_row_ff <= cur_row_ff;
            cell_col_ff <= cur_col_ff;
         end
      end
      if (state_ff == cclr_pkg::ST_STORE) begin
         second_ff   <= 1'b1;
         with_cur_ff <= 1'b1;
         last_ff     <= 1'b1;
      end
      if (state_ff == cclr_pkg::ST_CLR_STORE) begin
         last_ff <= row_end && col_end;
      end
      if (state_ff == cclr_pkg::ST_NEXT && state_in == cclr_pkg::ST_CLR_STORE) begin
         if (col_end) begin
            cell_col_ff <= '0;
            cell_row_ff <= cell_row_ff + 8'd1;
         end else begin
            cell_col_ff <= cell_col_ff + 8'd1;
         end
      end
      if (ctl.out_load) begin
         rsp_row_ff  <= cell_row_ff[1:0];
         rsp_col_ff  <= cell_col_ff[3:0];
         rsp_pix_ff  <= pix;
         rsp_last_ff <= last_ff;
      end
   end

   // Text memory with a valid bit per entry.
   always_ff @(posedge clock) begin
      if (ctl.text_we) begin
         text_mem[text_idx] <= ctl.text_wdata;
      end
      text_rd_ff     <= text_mem[text_idx];
      text_vld_rd_ff <= text_vld_ff[text_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         text_vld_ff <= '0;
      end else if (ctl.text_we) begin
         text_vld_ff[text_idx] <= 1'b1;
      end
   end

   // Font memory, one glyph per row, one write lane per glyph line.
   always_ff @(posedge clock) begin
      for (int l = 0; l < cclr_pkg::GLYPH_LINES; l++) begin
         if (ctl.font_we && ctl.font_lane_en[l]) begin
            font_mem[ctl.font_waddr][l*cclr_pkg::LINE_PIX +: cclr_pkg::LINE_PIX] <= ctl.font_wdata;
         end
      end
      font_rd_ff  <= font_mem[text_code[FC_W-1:0]];
      code_big_ff <= code_big;
   end

   assign q_pop            = ctl.pop;
   assign status.init_busy = (state_ff == cclr_pkg::ST_INIT);
   assign status.idle      = (state_ff == cclr_pkg::ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_cell_row     = rsp_row_ff;
   assign rsp_cell_col     = rsp_col_ff;
   assign rsp_cell_pixels  = rsp_pix_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

[rtl/core/character_lcd_cell_renderer.sv]
// Character LCD cell renderer: keeps a text store, a 5x8 font, a cursor and a blink phase,
// and sends out the 40-pixel bitmap of every active cell that a command touches.
// Depends on cclr_pkg, cclr_queue, cclr_front, cclr_back and the defines header.
//
// Requests are taken into a two-entry queue, so a new request can be accepted while the
// renderer works on an earlier one and while a finished result waits at the output register.
// Each rendered cell goes through one text read, one glyph row read and one output load on
// the text and font memories, in the sequencer states text, font, emit and next. A write
// char renders the same cell twice around the store, set cursor and blink phase render one
// cell, clear stores a space and renders each active cell in turn, a font line load is
// done in the idle state, and unused command codes are dropped at the front. A cell outside
// the active area skips the glyph read and the output; while rsp_stall holds a waiting
// result, the sequencer waits in the emit state. After reset the font memory is cleared
// one glyph row per cycle; requests are stalled during that pass, while register writes
// are taken as always. Registers are meant to be written only while the block is idle.
// The last result of a command carries rsp_last.
`include "character_lcd_cell_renderer_defines.svh"

module character_lcd_cell_renderer #(
   parameter int TEXT_ROWS  = cclr_pkg::TEXT_ROWS_DEF,
   parameter int TEXT_COLS  = cclr_pkg::TEXT_COLS_DEF,
   parameter int FONT_CHARS = cclr_pkg::FONT_CHARS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [2:0]                          req_cmd,
   input  logic [7:0]                          req_char_code,
   input  logic [7:0]                          req_cursor_row,
   input  logic [7:0]                          req_cursor_col,
   input  logic                                req_blink_phase,
   input  logic [2:0]                          req_font_line,
   input  logic [4:0]                          req_font_bits,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_cell_row,
   output logic [3:0]                          rsp_cell_col,
   output logic [cclr_pkg::GLYPH_BITS-1:0]     rsp_cell_pixels,
   output logic                                rsp_last,

   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cclr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [cclr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   cclr_pkg::cfg_type         cfg_ff;
   cclr_pkg::back_status_type back_status;
   cclr_pkg::cmd_type         q_push_data;
   cclr_pkg::cmd_type         q_head;
   logic                      q_push, q_full, q_pop, q_not_empty;

   // The register port never waits; writes go straight into the configuration register.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.num_cols      <= cclr_pkg::NUM_COLS_RST;
         cfg_ff.num_rows      <= cclr_pkg::NUM_ROWS_RST;
         cfg_ff.underline_en  <= 1'b0;
         cfg_ff.blink_enabled <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cclr_pkg::CSR_NUM_COLS:      cfg_ff.num_cols      <= csr_wdata[4:0];
            cclr_pkg::CSR_NUM_ROWS:      cfg_ff.num_rows      <= csr_wdata[2:0];
            cclr_pkg::CSR_UNDERLINE_EN:  cfg_ff.underline_en  <= csr_wdata[0];
            cclr_pkg::CSR_BLINK_ENABLED: cfg_ff.blink_enabled <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // The front classifies requests and drops unused command codes.
   cclr_front u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_char_code   (req_char_code),
      .req_cursor_row  (req_cursor_row),
      .req_cursor_col  (req_cursor_col),
      .req_blink_phase (req_blink_phase),
      .req_font_line   (req_font_line),
      .req_font_bits   (req_font_bits),
      .q_full          (q_full),
      .back_status     (back_status),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   // The queue decouples request acceptance from rendering.
   cclr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // The back holds all display state and renders cells one at a time.
   cclr_back #(
      .TEXT_ROWS  (TEXT_ROWS),
      .TEXT_COLS  (TEXT_COLS),
      .FONT_CHARS (FONT_CHARS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg_ff),
      .q_not_empty     (q_not_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .status          (back_status),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_cell_col    (rsp_cell_col),
      .rsp_cell_pixels (rsp_cell_pixels),
      .rsp_last        (rsp_last)
   );

   // No request may enter while the font memory is still being cleared.
   `CCLR_ASSERT_IMP(a_no_req_during_init, clock, reset, back_status.init_busy, req_stall,
                    "request taken during font clearing")
   // A result only appears after the sequencer has been rendering.
   `CCLR_ASSERT_IMP(a_rsp_from_render, clock, reset, $rose(rsp_valid),
                    $past(!back_status.idle), "result without a render")
   // The clearing pass never produces results.
   `CCLR_ASSERT_NEVER(a_no_rsp_during_init, clock, reset, back_status.init_busy && rsp_valid,
                      "result during font clearing")
   // The front never pushes into a full queue.
   `CCLR_ASSERT_NEVER(a_queue_overflow, clock, reset, q_push && q_full,
                      "command queue overflow")

endmodule

[sim/character_lcd_cell_checker.sv]
// Checker for the character LCD cell renderer: watches the request, result and register
// channels, predicts each rendered cell and compares it. Depends on cclr_pkg.
module character_lcd_cell_checker
   import cclr_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [2:0]             req_cmd,
   input  logic [7:0]             req_char_code,
   input  logic [7:0]             req_cursor_row,
   input  logic [7:0]             req_cursor_col,
   input  logic                   req_blink_phase,
   input  logic [2:0]             req_font_line,
   input  logic [4:0]             req_font_bits,

   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [1:0]             rsp_cell_row,
   input  logic [3:0]             rsp_cell_col,
   input  logic [GLYPH_BITS-1:0]  rsp_cell_pixels,
   input  logic                   rsp_last,

   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,

   output int                     fail_count,
   output int                     cells_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROWS  = TEXT_ROWS_DEF;
   localparam int COLS  = TEXT_COLS_DEF;
   localparam int GLYPHS = FONT_CHARS_DEF;

   typedef struct packed {
      logic [1:0]            row;
      logic [3:0]            col;
      logic [GLYPH_BITS-1:0] pixels;
      logic                  last;
   } lcd_cell_type;

   lcd_cell_type expected_cells[$];
   logic [7:0] text_mem [0:ROWS*COLS-1];
   logic [4:0] font_mem [0:GLYPHS*GLYPH_LINES-1];
   logic [7:0] cursor_row;
   logic [7:0] cursor_col;
   logic       blink_inverted;
   logic [4:0] cols_reg;
   logic [2:0] rows_reg;
   logic       underline_reg;
   logic       blink_reg;
   int         mismatches = 0;

   function automatic int active_rows();
      return (rows_reg < ROWS) ? int'(rows_reg) : ROWS;
   endfunction

   function automatic int active_cols();
      return (cols_reg < COLS) ? int'(cols_reg) : COLS;
   endfunction

   function automatic bit cell_active(input int r, input int c);
      return r < active_rows() && c < active_cols();
   endfunction

   // Appends the bitmap of one cell; cells outside the active area produce nothing.
   function automatic void render_cell(input int r, input int c, input bit with_cursor);
      lcd_cell_type entry;
      logic [7:0]   code;
      logic [4:0]   line_bits;
      bit           here;
      int           i;
      if (!cell_active(r, c))
         return;
      code = text_mem[r * COLS + c];
      here = with_cursor && r == int'(cursor_row) && c == int'(cursor_col);
      entry.pixels = '0;
      for (i = 0; i < GLYPH_LINES; i++) begin
         line_bits = font_mem[int'(code) * GLYPH_LINES + i];
         if (here && blink_reg && blink_inverted)
            line_bits = '1;
         else if (here && underline_reg && i >= GLYPH_LINES - 2)
            line_bits = '1;
         entry.pixels = {entry.pixels[GLYPH_BITS-LINE_PIX-1:0], line_bits};
      end
      entry.row  = 2'(r);
      entry.col  = 4'(c);
      entry.last = 1'b0;
      expected_cells.push_back(entry);
   endfunction

   function automatic void apply_command();
      int           start;
      int           r;
      int           c;
      lcd_cell_type tail;
      start = expected_cells.size();
      case (req_cmd)
         CMD_WRITE_CHAR: begin
            r = cursor_row;
            c = cursor_col;
            render_cell(r, c, 1'b0);
            if (cell_active(r, c))
               text_mem[r * COLS + c] = req_char_code;
            if (cursor_col != 8'hFF)
               cursor_col = cursor_col + 8'd1;
            render_cell(r, c, 1'b1);
         end
         CMD_SET_CURSOR: begin
            render_cell(cursor_row, cursor_col, 1'b0);
            cursor_row = req_cursor_row;
            cursor_col = req_cursor_col;
         end
         CMD_CLEAR: begin
            for (r = 0; r < active_rows(); r++)
               for (c = 0; c < active_cols(); c++) begin
                  text_mem[r * COLS + c] = SPACE_CODE;
                  render_cell(r, c, 1'b0);
               end
            cursor_row = '0;
            cursor_col = '0;
         end
         CMD_BLINK_PHASE: begin
            blink_inverted = req_blink_phase;
            render_cell(cursor_row, cursor_col, 1'b1);
         end
         CMD_LOAD_FONT:
            font_mem[int'(req_char_code) * GLYPH_LINES + int'(req_font_line)] = req_font_bits;
         default: ;
      endcase
      // The final cell of the command carries the last flag.
      if (expected_cells.size() > start) begin
         tail = expected_cells.pop_back();
         tail.last = 1'b1;
         expected_cells.push_back(tail);
      end
   endfunction

   function automatic void write_register();
      case (csr_index)
         CSR_NUM_COLS:      cols_reg = csr_wdata[4:0];
         CSR_NUM_ROWS:      rows_reg = csr_wdata[2:0];
         CSR_UNDERLINE_EN:  underline_reg = csr_wdata[0];
         CSR_BLINK_ENABLED: blink_reg = csr_wdata[0];
         default: ;
      endcase
   endfunction

   function automatic void check_cell();
      lcd_cell_type want;
      if (expected_cells.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("[%0t] unexpected cell row %0d col %0d pixels %h last %b", $realtime,
                     rsp_cell_row, rsp_cell_col, rsp_cell_pixels, rsp_last);
         return;
      end
      want = expected_cells.pop_front();
      if (want.row !== rsp_cell_row || want.col !== rsp_cell_col ||
          want.pixels !== rsp_cell_pixels || want.last !== rsp_last) begin
         mismatches++;
         if (mismatches <= 10)
            $display({"[%0t] cell mismatch: expected row %0d col %0d pixels %h last %b,",
                      " got row %0d col %0d pixels %h last %b"},
                     $realtime, want.row, want.col, want.pixels, want.last,
                     rsp_cell_row, rsp_cell_col, rsp_cell_pixels, rsp_last);
      end
   endfunction

   // Results are checked before the request of the same edge is predicted, since a result
   // leaving now can only belong to an earlier request.
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ROWS * COLS; i++)
            text_mem[i] = SPACE_CODE;
         for (int i = 0; i < GLYPHS * GLYPH_LINES; i++)
            font_mem[i] = '0;
         cursor_row     = '0;
         cursor_col     = '0;
         blink_inverted = 1'b0;
         cols_reg       = NUM_COLS_RST;
         rows_reg       = NUM_ROWS_RST;
         underline_reg  = 1'b0;
         blink_reg      = 1'b0;
         expected_cells.delete();
      end else begin
         if (rsp_valid && !rsp_stall)
            check_cell();
         if (csr_valid && csr_ready)
            write_register();
         if (req_valid && !req_stall)
            apply_command();
      end
      cells_pending <= expected_cells.size();
      fail_count    <= mismatches;
   end

endmodule

[sim/character_lcd_cell_renderer_tb.sv]
// Testbench top for the character LCD cell renderer: drives requests, register writes
// and result stalls, and gives the verdict. Depends on cclr_pkg, the RTL and the checker.
module character_lcd_cell_renderer_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import cclr_pkg::*;

   // Generous bound: far beyond a run where every request is a full clear and every
   // result waits out the longest stall.
   localparam int CYCLE_LIMIT   = 2000000;
   // Cycles allowed for requests without results still in the block's queue.
   localparam int DRAIN_CYCLES  = 30;
   localparam int PHASES        = 8;
   localparam int PHASE_ITEMS   = 32;
   // An index that no register answers to; writes there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 3'd5;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [2:0]            req_cmd = CMD_WRITE_CHAR;
   logic [7:0]            req_char_code = '0;
   logic [7:0]            req_cursor_row = '0;
   logic [7:0]            req_cursor_col = '0;
   logic                  req_blink_phase = 1'b0;
   logic [2:0]            req_font_line = '0;
   logic [4:0]            req_font_bits = '0;

   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_cell_row;
   logic [3:0]            rsp_cell_col;
   logic [GLYPH_BITS-1:0] rsp_cell_pixels;
   logic                  rsp_last;

   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int cells_pending;
   int cycle_count = 0;

   // Idle controls: percent chance of a gap or stall burst, and the quiet final stretch.
   int gap_pct = 0;
   int stall_pct = 0;
   bit calm = 1'b0;
   int stall_left = 0;

   character_lcd_cell_renderer u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_char_code   (req_char_code),
      .req_cursor_row  (req_cursor_row),
      .req_cursor_col  (req_cursor_col),
      .req_blink_phase (req_blink_phase),
      .req_font_line   (req_font_line),
      .req_font_bits   (req_font_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_cell_col    (rsp_cell_col),
      .rsp_cell_pixels (rsp_cell_pixels),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   character_lcd_cell_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_char_code   (req_char_code),
      .req_cursor_row  (req_cursor_row),
      .req_cursor_col  (req_cursor_col),
      .req_blink_phase (req_blink_phase),
      .req_font_line   (req_font_line),
      .req_font_bits   (req_font_bits),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_cell_row    (rsp_cell_row),
      .rsp_cell_col    (rsp_cell_col),
      .rsp_cell_pixels (rsp_cell_pixels),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .cells_pending   (cells_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Result-side back pressure. A burst holds stall high until its countdown, drawn at random
   // when it starts, runs out; between bursts a new one starts with the chance set for the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(99) < stall_pct) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(15, 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Presents one request and holds it until the block takes it. Valid stays high for a
   // following request unless an idle burst is drawn, so it is never dropped and raised
   // again in the same step.
   task automatic send_request(input logic [2:0] cmd, input logic [7:0] code,
                               input logic [7:0] row, input logic [7:0] col,
                               input logic phase, input logic [2:0] line,
                               input logic [4:0] bits);
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_char_code   <= code;
      req_cursor_row  <= row;
      req_cursor_col  <= col;
      req_blink_phase <= phase;
      req_font_line   <= line;
      req_font_bits   <= bits;
      do @(posedge clock); while (req_stall);
      if (!calm && $urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(16, 1)) @(posedge clock);
      end
   endtask

   // Valid stays high across back-to-back writes; the caller lowers it afterwards.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic setup_display(input logic [4:0] cols, input logic [2:0] rows,
                                input logic underline, input logic blink);
      write_register(CSR_NUM_COLS, cols);
      write_register(CSR_NUM_ROWS, 5'(rows));
      write_register(CSR_UNDERLINE_EN, 5'(underline));
      write_register(CSR_BLINK_ENABLED, 5'(blink));
      csr_valid <= 1'b0;
   endtask

   // Stops sending, waits for every predicted cell, then lets font loads still queued inside
   // the block drain out before anything else happens. The first edge is always waited for,
   // since the count seen here is registered in the checker.
   task automatic wait_idle();
      req_valid <= 1'b0;
      do @(posedge clock); while (cells_pending != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Character codes are mostly drawn from a small set whose glyphs get loaded, so that
   // rendered cells show real pixels; the rest cover the whole code range.
   function automatic logic [7:0] pick_code();
      int r;
      r = $urandom_range(9);
      if (r < 5)
         return 8'h40 + 8'($urandom_range(7));
      else if (r == 5)
         return SPACE_CODE;
      return 8'($urandom_range(255));
   endfunction

   task automatic send_random_request();
      int         pick;
      logic [2:0] cmd;
      logic [7:0] row;
      logic [7:0] col;
      pick = $urandom_range(99);
      // Cursor moves mostly land in or just past the text area; some go anywhere.
      if ($urandom_range(9) < 7) begin
         row = 8'($urandom_range(4));
         col = 8'($urandom_range(17));
      end else begin
         row = 8'($urandom_range(255));
         col = 8'($urandom_range(255));
      end
      if (pick < 35)
         cmd = CMD_WRITE_CHAR;
      else if (pick < 50)
         cmd = CMD_SET_CURSOR;
      else if (pick < 55)
         cmd = CMD_CLEAR;
      else if (pick < 70)
         cmd = CMD_BLINK_PHASE;
      else if (pick < 95)
         cmd = CMD_LOAD_FONT;
      else
         cmd = 3'($urandom_range(7, CMD_LOAD_FONT + 1));
      send_request(cmd, pick_code(), row, col, 1'($urandom_range(1)),
                   3'($urandom_range(7)), 5'($urandom_range(31)));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // The block clears its font after reset and stalls requests meanwhile; register
      // writes are accepted during that pass. The spare index must be ignored.
      write_register(CSR_SPARE, 5'd31);
      setup_display(5'd16, 3'd2, 1'b1, 1'b1);

      // Directed part. Glyphs at both ends of the code range and of the line range,
      // plus one for the space character so that a clear renders visible pixels.
      gap_pct   = 20;
      stall_pct = 20;
      send_request(CMD_LOAD_FONT, 8'h41, 8'd0, 8'd0, 1'b0, 3'd0, 5'b11111);
      send_request(CMD_LOAD_FONT, 8'h41, 8'd0, 8'd0, 1'b0, 3'd7, 5'b10101);
      send_request(CMD_LOAD_FONT, SPACE_CODE, 8'd0, 8'd0, 1'b0, 3'd3, 5'b00100);
      send_request(CMD_LOAD_FONT, 8'hFF, 8'd0, 8'd0, 1'b0, 3'd5, 5'b01010);
      send_request(CMD_LOAD_FONT, 8'h00, 8'd0, 8'd0, 1'b0, 3'd1, 5'b00000);

      // Writes along row 0, then both blink phases on the cursor cell: all pixels on,
      // then the underline.
      send_request(CMD_WRITE_CHAR, 8'h41, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);
      send_request(CMD_WRITE_CHAR, 8'hFF, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);
      send_request(CMD_WRITE_CHAR, 8'h00, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);
      send_request(CMD_BLINK_PHASE, 8'd0, 8'd0, 8'd0, 1'b1, 3'd0, 5'd0);
      send_request(CMD_BLINK_PHASE, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);

      // Last column of the last active row, then a write there and one that runs off the edge
      // of the area: the column still advances but nothing is stored or rendered.
      send_request(CMD_SET_CURSOR, 8'd0, 8'd1, 8'd15, 1'b0, 3'd0, 5'd0);
      send_request(CMD_BLINK_PHASE, 8'd0, 8'd0, 8'd0, 1'b1, 3'd0, 5'd0);
      send_request(CMD_WRITE_CHAR, 8'h41, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);
      send_request(CMD_WRITE_CHAR, 8'h42, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);

      // Cursor at the top of its range: the column saturates and nothing renders.
      send_request(CMD_SET_CURSOR, 8'd0, 8'hFF, 8'hFF, 1'b0, 3'd0, 5'd0);
      send_request(CMD_WRITE_CHAR, 8'h41, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);
      send_request(CMD_BLINK_PHASE, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);

      // Back home, with the block cursor over a written cell.
      send_request(CMD_SET_CURSOR, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);
      send_request(CMD_BLINK_PHASE, 8'd0, 8'd0, 8'd0, 1'b1, 3'd0, 5'd0);

      // Unused command codes must be dropped without results.
      for (int k = CMD_LOAD_FONT + 1; k < 8; k++)
         send_request(3'(k), 8'hFF, 8'hFF, 8'hFF, 1'b1, 3'd7, 5'b11111);

      // A clear renders every active cell, then a space is written at the start of row 1.
      send_request(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);
      send_request(CMD_SET_CURSOR, 8'd0, 8'd1, 8'd0, 1'b0, 3'd0, 5'd0);
      send_request(CMD_WRITE_CHAR, SPACE_CODE, 8'd0, 8'd0, 1'b0, 3'd0, 5'd0);

      // Random part, one phase per display setting. The sender stops and waits for every
      // result before each register change. Idle rates rotate so some phases run without
      // gaps or stalls, and the last phase runs with none at all.
      for (int p = 0; p < PHASES; p++) begin
         wait_idle();
         case (p)
            0: setup_display(5'd16, 3'd4, 1'b1, 1'b0);
            1: setup_display(5'd16, 3'd2, 1'b0, 1'b1);
            2: setup_display(5'd1, 3'd1, 1'b1, 1'b1);
            3: setup_display(5'd0, 3'd3, 1'b1, 1'b1);
            4: setup_display(5'd31, 3'd7, 1'b1, 1'b0);
            5: setup_display(5'd5, 3'd0, 1'b0, 1'b1);
            6: setup_display(5'd9, 3'd3, 1'b1, 1'b1);
            default: setup_display(5'd16, 3'd4, 1'b1, 1'b1);
         endcase
         gap_pct   = (p % 3) * 25;
         stall_pct = ((p + 1) % 3) * 20;
         calm      = (p == PHASES - 1);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_random_request();
      end

      wait_idle();
      if (fail_count == 0 && cells_pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
